[src/idhp_pkg.sv]
// ---------------------------------------------------------------------------
// Image dimension header parser package
// Shared types, marker constants and the parser state record.
// ---------------------------------------------------------------------------
package idhp_pkg;

    // Parse phases of the byte walker.
    typedef enum logic [3:0] {
        PH_SIG    = 4'd0,
        PH_SCAN   = 4'd1,
        PH_MARK   = 4'd2,
        PH_LENHI  = 4'd3,
        PH_LENLO  = 4'd4,
        PH_FIELDS = 4'd5,
        PH_SKIP   = 4'd6,
        PH_PNG    = 4'd7,
        PH_IDLE   = 4'd8
    } t_phase;

    // Format codes reported on the result.
    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_PNG  = 2'd1;
    localparam logic [1:0] FMT_JPEG = 2'd2;

    // Byte positions of interest.
    localparam logic [4:0] POS_SAT       = 5'd24;
    localparam logic [4:0] POS_SIG_PNG   = 5'd8;
    localparam logic [4:0] POS_SIG_JPEG  = 5'd2;
    localparam logic [4:0] POS_JPEG_DONE = 5'd1;
    localparam logic [4:0] POS_PNG_DONE  = 5'd7;
    localparam logic [4:0] POS_W_FIRST   = 5'd16;
    localparam logic [4:0] POS_W_LAST    = 5'd19;
    localparam logic [4:0] POS_H_FIRST   = 5'd20;
    localparam logic [4:0] POS_H_LAST    = 5'd23;

    // JPEG marker bytes.
    localparam logic [7:0] MK_FILL   = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_STUFF  = 8'h00;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF2   = 8'hC2;

    // Segment length overheads.
    localparam logic [15:0] LEN_PLAIN = 16'd2;
    localparam logic [15:0] LEN_SOF   = 16'd7;

    // SOF field indexes.
    localparam logic [2:0] FLD_PREC  = 3'd0;
    localparam logic [2:0] FLD_H_HI  = 3'd1;
    localparam logic [2:0] FLD_H_LO  = 3'd2;
    localparam logic [2:0] FLD_W_HI  = 3'd3;
    localparam logic [2:0] FLD_W_LO  = 3'd4;

    // Complete parser state.
    typedef struct packed {
        logic [4:0]  byte_position;
        logic        png_match;
        logic        jpeg_match;
        t_phase      parse_phase;
        logic [15:0] segment_remaining;
        logic [7:0]  length_high;
        logic [2:0]  field_index;
        logic [7:0]  current_marker;
        logic [31:0] width_store;
        logic [31:0] height_store;
        logic [7:0]  precision_store;
        logic        progressive_store;
        logic        found_store;
    } t_state;

    // One result item.
    typedef struct packed {
        logic [1:0]  image_format;
        logic        frame_found;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  sample_precision;
        logic        progressive;
    } t_result;

    localparam t_state ST_RESET = '{
        byte_position:     5'd0,
        png_match:         1'b1,
        jpeg_match:        1'b1,
        parse_phase:       PH_SIG,
        segment_remaining: 16'd0,
        length_high:       8'd0,
        field_index:       3'd0,
        current_marker:    8'd0,
        width_store:       32'd0,
        height_store:      32'd0,
        precision_store:   8'd0,
        progressive_store: 1'b0,
        found_store:       1'b0
    };

    // PNG signature byte at a given position.
    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // JPEG signature byte at a given position.
    function automatic logic [7:0] jpeg_sig_byte(input logic idx);
        return idx ? MK_SOI : MK_FILL;
    endfunction

endpackage

[src/idhp_step.sv]
// ---------------------------------------------------------------------------
// Parser step
// Works out the next parser state and the result for one byte.
// ---------------------------------------------------------------------------
module idhp_step
    import idhp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    output t_state     o_next_state,
    output t_result    o_result
);

    t_state nx;

    // Next state for one byte.
    always_comb begin
        logic [4:0]  p;
        logic [7:0]  b;
        logic [15:0] len;
        logic [15:0] rem;
        nx  = i_state;
        p   = i_state.byte_position;
        b   = i_data_byte;
        len = {i_state.length_high, b};
        rem = i_state.segment_remaining;
        case (i_state.parse_phase)
            PH_SIG: begin
                if (p < POS_SIG_PNG && b != png_sig_byte(p[2:0])) begin
                    nx.png_match = 1'b0;
                end
                if (p < POS_SIG_JPEG && b != jpeg_sig_byte(p[0])) begin
                    nx.jpeg_match = 1'b0;
                end
                if (p == POS_JPEG_DONE && nx.jpeg_match) begin
                    nx.parse_phase = PH_SCAN;
                end else if (p == POS_PNG_DONE && nx.png_match) begin
                    nx.parse_phase = PH_PNG;
                end else if (!nx.png_match && !nx.jpeg_match) begin
                    nx.parse_phase = PH_IDLE;
                end
            end
            PH_PNG: begin
                if (p >= POS_W_FIRST && p <= POS_W_LAST) begin
                    nx.width_store = {i_state.width_store[23:0], b};
                end else if (p >= POS_H_FIRST && p <= POS_H_LAST) begin
                    nx.height_store = {i_state.height_store[23:0], b};
                    if (p == POS_H_LAST) begin
                        nx.found_store = 1'b1;
                    end
                end
            end
            PH_SCAN: begin
                if (b == MK_FILL) begin
                    nx.parse_phase = PH_MARK;
                end
            end
            PH_MARK: begin
                if (b == MK_FILL) begin
                    nx.parse_phase = PH_MARK;
                end else if (b == MK_STUFF || (b >= MK_RST0 && b <= MK_EOI)) begin
                    nx.parse_phase = PH_SCAN;
                end else begin
                    nx.current_marker = b;
                    if (b == MK_SOF0 || b == MK_SOF2) begin
                        nx.found_store = 1'b0;
                    end
                    nx.parse_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                nx.length_high = b;
                nx.parse_phase = PH_LENLO;
            end
            PH_LENLO: begin
                if (i_state.current_marker == MK_SOF0 ||
                    i_state.current_marker == MK_SOF2) begin
                    nx.segment_remaining = (len < LEN_SOF) ? 16'd0 : len - LEN_SOF;
                    nx.field_index       = FLD_PREC;
                    nx.parse_phase       = PH_FIELDS;
                end else begin
                    nx.segment_remaining = (len < LEN_PLAIN) ? 16'd0 : len - LEN_PLAIN;
                    nx.parse_phase = (len > LEN_PLAIN) ? PH_SKIP : PH_SCAN;
                end
            end
            PH_FIELDS: begin
                case (i_state.field_index)
                    FLD_PREC: nx.precision_store = b;
                    FLD_H_HI: nx.height_store    = {16'd0, b, 8'd0};
                    FLD_H_LO: nx.height_store    = i_state.height_store | {24'd0, b};
                    FLD_W_HI: nx.width_store     = {16'd0, b, 8'd0};
                    default: begin
                        nx.width_store       = i_state.width_store | {24'd0, b};
                        nx.found_store       = 1'b1;
                        nx.progressive_store = (i_state.current_marker == MK_SOF2);
                    end
                endcase
                if (i_state.field_index >= FLD_W_LO) begin
                    nx.field_index = FLD_PREC;
                    nx.parse_phase = (rem != 16'd0) ? PH_SKIP : PH_SCAN;
                end else begin
                    nx.field_index = i_state.field_index + 3'd1;
                end
            end
            PH_SKIP: begin
                if (rem != 16'd0) begin
                    nx.segment_remaining = rem - 16'd1;
                end
                if (rem <= 16'd1) begin
                    nx.parse_phase = PH_SCAN;
                end
            end
            default: begin
                nx.parse_phase = i_state.parse_phase;
            end
        endcase
        if (p < POS_SAT) begin
            nx.byte_position = p + 5'd1;
        end
    end

    assign o_next_state = nx;

    // Result fields as seen after this byte.
    always_comb begin
        logic [1:0] fmt;
        logic       found;
        case (nx.parse_phase)
            PH_PNG:  fmt = FMT_PNG;
            PH_SCAN, PH_MARK, PH_LENHI, PH_LENLO, PH_FIELDS, PH_SKIP: fmt = FMT_JPEG;
            default: fmt = FMT_NONE;
        endcase
        found = (fmt != FMT_NONE) && nx.found_store;
        o_result.image_format     = fmt;
        o_result.frame_found      = found;
        o_result.image_width      = found ? nx.width_store : 32'd0;
        o_result.image_height     = found ? nx.height_store : 32'd0;
        o_result.sample_precision = (found && fmt == FMT_JPEG) ? nx.precision_store : 8'd0;
        o_result.progressive      = found && fmt == FMT_JPEG && nx.progressive_store;
    end

endmodule

[src/idhp_out_reg.sv]
// ---------------------------------------------------------------------------
// Result register
// Holds one result request until the consumer takes it.
// ---------------------------------------------------------------------------
module idhp_out_reg
    import idhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Valid flag: set on load, cleared when taken without a new load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

[src/image_dimension_header_parser.sv]
// A result is registered: it appears in the cycle after the byte flagged as last is accepted.
// Throughput: one byte per cycle; the whole per-byte update is one pass of logic.
// A new byte is taken while the result register is empty or being emptied.
// Reset (synchronous, active low) returns the parser to the signature phase
// and empties the result register; state also returns there after each last byte.
// ---------------------------------------------------------------------------
// Image dimension header parser
// Reads PNG or JPEG files byte by byte and reports format and dimensions.
// ---------------------------------------------------------------------------
module image_dimension_header_parser
    import idhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_image_format,
    output logic        o_frame_found,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [7:0]  o_sample_precision,
    output logic        o_progressive
);

    t_state  r_state;
    t_state  n_state;
    t_state  step_state;
    t_result step_result;
    t_result out_result;
    logic    in_fire;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    idhp_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .o_next_state (step_state),
        .o_result     (step_result)
    );

    // Parser state: back to the start after each file.
    always_comb begin
        n_state = r_state;
        if (in_fire) begin
            n_state = i_last_byte ? ST_RESET : step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    idhp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire && i_last_byte),
        .i_result    (step_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_image_format     = out_result.image_format;
    assign o_frame_found      = out_result.frame_found;
    assign o_image_width      = out_result.image_width;
    assign o_image_height     = out_result.image_height;
    assign o_sample_precision = out_result.sample_precision;
    assign o_progressive      = out_result.progressive;

    // The last byte of a file always leaves the parser at the start.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_last_byte |=> r_state.parse_phase == PH_SIG &&
                                   r_state.byte_position == 5'd0)
        else $error("parser did not restart after last byte");

    // A found frame implies a recognised format.
    a_found_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_found |-> o_image_format != FMT_NONE)
        else $error("frame found on unrecognised file");

    // JPEG-only fields stay clear for other formats.
    a_jpeg_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_format != FMT_JPEG |->
            o_sample_precision == 8'd0 && !o_progressive)
        else $error("jpeg fields set on non-jpeg result");

    // The byte counter saturates.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_position <= POS_SAT)
        else $error("byte position beyond saturation");

    // A waiting result is never overwritten by a request that is not accepted.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(out_result))
        else $error("pending result lost");

endmodule

[bench/header_parse_checker.sv]
// ---------------------------------------------------------------------------
// Header parse checker
// Watches both channels of the image dimension header parser, predicts the
// result for every file from the accepted bytes, and compares each result
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module header_parse_checker
    import idhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_image_format,
    input  logic        i_frame_found,
    input  logic [31:0] i_image_width,
    input  logic [31:0] i_image_height,
    input  logic [7:0]  i_sample_precision,
    input  logic        i_progressive,
    output int          o_pending,
    output int          o_fail_count
);

    // The eight PNG signature bytes, first byte in the top octet.
    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

    // Predicted parser state.
    logic [4:0]  pos;
    logic        png_ok;
    logic        jpg_ok;
    t_phase      phase;
    logic [15:0] remain;
    logic [7:0]  len_hi;
    logic [2:0]  fld;
    logic [7:0]  marker;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [7:0]  prec;
    logic        prog;
    logic        found;

    t_result expected_headers [$];
    t_result oldest;
    int      fail_total = 0;

    // Return the predicted state to its start-of-file values.
    task automatic clear_parser();
        pos    = '0;
        png_ok = 1'b1;
        jpg_ok = 1'b1;
        phase  = PH_SIG;
        remain = '0;
        len_hi = '0;
        fld    = '0;
        marker = '0;
        wid    = '0;
        hgt    = '0;
        prec   = '0;
        prog   = 1'b0;
        found  = 1'b0;
    endtask

    // Advance the predicted parser by one byte; on the last byte of a file,
    // queue the header that the block should report.
    task automatic parse_byte(input logic [7:0] b, input logic last_flag);
        logic [15:0] seg_len;
        logic        is_sof;
        t_result     res;
        is_sof = (marker == MK_SOF0) || (marker == MK_SOF2);
        case (phase)
            PH_SIG: begin
                if (pos < 5'd8 && b != PNG_MAGIC[63 - 8 * pos[2:0] -: 8]) png_ok = 1'b0;
                if (pos < 5'd2 && b != (pos[0] ? MK_SOI : MK_FILL)) jpg_ok = 1'b0;
                if (pos == 5'd1 && jpg_ok) begin
                    phase = PH_SCAN;
                end else if (pos == 5'd7 && png_ok) begin
                    phase = PH_PNG;
                end else if (!png_ok && !jpg_ok) begin
                    phase = PH_IDLE;
                end
            end
            PH_PNG: begin
                // Width occupies bytes 16 to 19 and height bytes 20 to 23.
                if (pos >= 5'd16 && pos <= 5'd19) begin
                    wid = {wid[23:0], b};
                end else if (pos >= 5'd20 && pos <= 5'd23) begin
                    hgt = {hgt[23:0], b};
                    if (pos == 5'd23) found = 1'b1;
                end
            end
            PH_SCAN: begin
                if (b == MK_FILL) phase = PH_MARK;
            end
            PH_MARK: begin
                // Fill bytes keep us here; markers without a length go back to scanning.
                if (b == MK_FILL) begin
                end else if (b == MK_STUFF || (b >= MK_RST0 && b <= MK_EOI)) begin
                    phase = PH_SCAN;
                end else begin
                    marker = b;
                    if (b == MK_SOF0 || b == MK_SOF2) found = 1'b0;
                    phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                len_hi = b;
                phase  = PH_LENLO;
            end
            PH_LENLO: begin
                seg_len = {len_hi, b};
                if (is_sof) begin
                    remain = (seg_len < 16'd7) ? 16'd0 : seg_len - 16'd7;
                    fld    = FLD_PREC;
                    phase  = PH_FIELDS;
                end else begin
                    remain = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
                    phase  = (remain != 16'd0) ? PH_SKIP : PH_SCAN;
                end
            end
            PH_FIELDS: begin
                case (fld)
                    FLD_PREC: prec = b;
                    FLD_H_HI: hgt  = {16'd0, b, 8'd0};
                    FLD_H_LO: hgt  = hgt | {24'd0, b};
                    FLD_W_HI: wid  = {16'd0, b, 8'd0};
                    default: begin
                        wid   = wid | {24'd0, b};
                        found = 1'b1;
                        prog  = (marker == MK_SOF2);
                    end
                endcase
                if (fld >= FLD_W_LO) begin
                    fld   = FLD_PREC;
                    phase = (remain != 16'd0) ? PH_SKIP : PH_SCAN;
                end else begin
                    fld = fld + 3'd1;
                end
            end
            PH_SKIP: begin
                if (remain != 16'd0) remain = remain - 16'd1;
                if (remain == 16'd0) phase = PH_SCAN;
            end
            default: begin
            end
        endcase
        if (pos < 5'd24) pos = pos + 5'd1;

        if (last_flag) begin
            if (phase == PH_PNG) begin
                res.image_format = FMT_PNG;
            end else if (phase >= PH_SCAN && phase <= PH_SKIP) begin
                res.image_format = FMT_JPEG;
            end else begin
                res.image_format = FMT_NONE;
            end
            res.frame_found      = (res.image_format != FMT_NONE) && found;
            res.image_width      = res.frame_found ? wid : 32'd0;
            res.image_height     = res.frame_found ? hgt : 32'd0;
            res.sample_precision =
                (res.frame_found && res.image_format == FMT_JPEG) ? prec : 8'd0;
            res.progressive      =
                (res.frame_found && res.image_format == FMT_JPEG) ? prog : 1'b0;
            expected_headers = {expected_headers, res};
            clear_parser();
        end
    endtask

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s differs, got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_total++;
    endtask

    // Results are checked before the byte of the same edge is predicted, since
    // a result is registered and so never appears in the same cycle as its last byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_headers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_headers.size() == 0) begin
                    report_mismatch("result with no file pending", 32'd0, 32'd0);
                end else begin
                    oldest = expected_headers.pop_front();
                    if (i_image_format !== oldest.image_format)
                        report_mismatch("image_format", 32'(i_image_format),
                                        32'(oldest.image_format));
                    if (i_frame_found !== oldest.frame_found)
                        report_mismatch("frame_found", 32'(i_frame_found),
                                        32'(oldest.frame_found));
                    if (i_image_width !== oldest.image_width)
                        report_mismatch("image_width", i_image_width, oldest.image_width);
                    if (i_image_height !== oldest.image_height)
                        report_mismatch("image_height", i_image_height, oldest.image_height);
                    if (i_sample_precision !== oldest.sample_precision)
                        report_mismatch("sample_precision", 32'(i_sample_precision),
                                        32'(oldest.sample_precision));
                    if (i_progressive !== oldest.progressive)
                        report_mismatch("progressive", 32'(i_progressive),
                                        32'(oldest.progressive));
                end
            end
            if (i_in_valid && i_in_ready) parse_byte(i_data_byte, i_last_byte);
        end
        o_pending    <= expected_headers.size();
        o_fail_count <= fail_total;
    end

endmodule

[bench/testbench.sv]
// ---------------------------------------------------------------------------
// Image dimension header parser testbench
// Sends directed and random PNG, JPEG and malformed files byte by byte, with
// random gaps on both channels, while a checker predicts and compares every
// reported header.
// ---------------------------------------------------------------------------
module testbench
    import idhp_pkg::*;
();

    localparam logic [63:0] PNG_MAGIC      = 64'h8950_4E47_0D0A_1A0A;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_BYTES    = 250;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = 8'd0;
    logic        last_byte  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  image_format;
    logic        frame_found;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_precision;
    logic        progressive;
    int          pending;
    int          fail_count;

    int          send_idle_pct = 29;
    int          recv_idle_pct = 65;
    int          idle_cycles   = 0;
    logic [7:0]  file_bytes [$];

    image_dimension_header_parser DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_last_byte        (last_byte),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_image_format     (image_format),
        .o_frame_found      (frame_found),
        .o_image_width      (image_width),
        .o_image_height     (image_height),
        .o_sample_precision (sample_precision),
        .o_progressive      (progressive)
    );

    header_parse_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_last_byte        (last_byte),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_image_format     (image_format),
        .i_frame_found      (frame_found),
        .i_image_width      (image_width),
        .i_image_height     (image_height),
        .i_sample_precision (sample_precision),
        .i_progressive      (progressive),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if nothing is accepted on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Present one byte as a request and hold it until it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic last_flag);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last_flag;
        do @(posedge clk); while (!in_ready);
    endtask

    // Send the assembled file, flagging its final byte, and empty the buffer.
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // Stop sending until every pending header has been reported.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Append one byte to the file being assembled.
    task automatic add_byte(input logic [7:0] b);
        file_bytes = {file_bytes, b};
    endtask

    task automatic push_random(input int n);
        repeat (n) add_byte(8'($urandom_range(255)));
    endtask

    task automatic trim_file(input int n);
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
    endtask

    // PNG signature, IHDR length and type, then width and height big-endian.
    task automatic push_png(input logic [31:0] w, input logic [31:0] h);
        for (int i = 0; i < 8; i++) add_byte(PNG_MAGIC[63 - 8 * i -: 8]);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h0D);
        add_byte(8'h49);
        add_byte(8'h48);
        add_byte(8'h44);
        add_byte(8'h52);
        for (int i = 3; i >= 0; i--) add_byte(w[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) add_byte(h[8 * i +: 8]);
    endtask

    // Marker segment whose body is random and as long as the length asks.
    task automatic push_plain(input logic [7:0] mk, input logic [15:0] len);
        add_byte(MK_FILL);
        add_byte(mk);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        for (int i = 2; i < len; i++) add_byte(8'($urandom_range(255)));
    endtask

    // Frame header: the five field bytes always follow, then any remainder.
    task automatic push_sof(input logic [7:0] mk, input logic [15:0] len,
                            input logic [7:0] p, input logic [15:0] h,
                            input logic [15:0] w);
        add_byte(MK_FILL);
        add_byte(mk);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        add_byte(p);
        add_byte(h[15:8]);
        add_byte(h[7:0]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
        for (int i = 7; i < len; i++) add_byte(8'($urandom_range(255)));
    endtask

    // Occasionally put extra fill bytes ahead of a marker.
    task automatic push_fill();
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) add_byte(MK_FILL);
    endtask

    // Build one random file: mostly well-formed PNG and JPEG streams with
    // random content, the rest broken signatures and noise.
    task automatic make_random_file();
        int          kind;
        int          choice;
        int          r;
        logic [7:0]  mk;
        logic [15:0] len;
        kind = $urandom_range(9);
        if (kind <= 2) begin
            push_png({$urandom}, {$urandom});
            push_random($urandom_range(0, 4));
        end else if (kind <= 7) begin
            add_byte(MK_FILL);
            add_byte(MK_SOI);
            repeat ($urandom_range(1, 6)) begin
                choice = $urandom_range(5);
                case (choice)
                    0: begin
                        do mk = 8'($urandom_range(255));
                        while (mk == MK_FILL || mk == MK_STUFF || mk == MK_SOF0 ||
                               mk == MK_SOF2 || (mk >= MK_RST0 && mk <= MK_EOI));
                        if ($urandom_range(99) == 0) len = 16'($urandom_range(300, 700));
                        else if ($urandom_range(7) == 0) len = 16'($urandom_range(1));
                        else len = 16'($urandom_range(2, 8));
                        push_fill();
                        push_plain(mk, len);
                    end
                    1, 2: begin
                        if ($urandom_range(3) == 0) len = 16'($urandom_range(6));
                        else len = 16'($urandom_range(7, 11));
                        push_fill();
                        push_sof($urandom_range(1) ? MK_SOF2 : MK_SOF0, len,
                                 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                                 16'($urandom_range(16'hFFFF)));
                    end
                    3: begin
                        r = $urandom_range(10);
                        add_byte(MK_FILL);
                        add_byte((r == 10) ? MK_STUFF : MK_RST0 + r[7:0]);
                    end
                    4: begin
                        // Entropy-coded data, with a stuffed FF now and then.
                        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(254)));
                        if ($urandom_range(5) == 0) begin
                            add_byte(MK_FILL);
                            add_byte(MK_STUFF);
                        end
                    end
                    default: begin
                        add_byte(MK_FILL);
                        add_byte(MK_EOI);
                    end
                endcase
            end
        end else if (kind == 8) begin
            // Broken signature followed by noise.
            if ($urandom_range(1)) begin
                push_png({$urandom}, {$urandom});
                trim_file(8);
                r = $urandom_range(7);
                file_bytes[r] = file_bytes[r] ^ (8'd1 << $urandom_range(7));
            end else begin
                add_byte(MK_FILL);
                do mk = 8'($urandom_range(255)); while (mk == MK_SOI);
                add_byte(mk);
            end
            push_random($urandom_range(0, 12));
        end else begin
            // Noise, either bare or behind a valid JPEG start.
            if ($urandom_range(1)) begin
                add_byte(MK_FILL);
                add_byte(MK_SOI);
                push_random($urandom_range(5, 30));
            end else begin
                push_random($urandom_range(1, 20));
            end
        end
        // Cut some files short at a random point.
        if ($urandom_range(4) == 0) trim_file($urandom_range(1, file_bytes.size()));
    endtask

    initial begin
        int sent;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // PNG with the widest width and a zero height, then a trailing byte.
        push_png(32'hFFFF_FFFF, 32'h0000_0000);
        push_random(1);
        send_file();
        // PNG ending exactly on the last height byte.
        push_png(32'h0000_0000, 32'hFFFF_FFFF);
        send_file();
        // PNG that stops one byte short of a complete height.
        push_png(32'h1234_5678, 32'h9ABC_DEF0);
        trim_file(23);
        send_file();
        // Complete signature only, then a signature missing its final byte.
        push_png(32'h0, 32'h0);
        trim_file(8);
        send_file();
        push_png(32'h0, 32'h0);
        trim_file(7);
        send_file();
        // Signature with a wrong final byte.
        push_png(32'h1, 32'h1);
        file_bytes[7] = 8'h0B;
        send_file();
        // One-byte files, a lone JPEG start and a lone JPEG end marker.
        add_byte(MK_FILL);
        send_file();
        add_byte(8'h00);
        send_file();
        add_byte(MK_FILL);
        add_byte(MK_SOI);
        send_file();
        add_byte(MK_FILL);
        add_byte(MK_EOI);
        send_file();

        // JPEG with fill bytes, markers without a length, short lengths,
        // a long segment and two frame headers, the later one progressive.
        add_byte(MK_FILL);
        add_byte(MK_SOI);
        add_byte(MK_FILL);
        add_byte(MK_FILL);
        push_plain(8'hE0, 16'd4);
        add_byte(MK_FILL);
        add_byte(MK_STUFF);
        add_byte(MK_FILL);
        add_byte(MK_RST0);
        add_byte(MK_FILL);
        add_byte(8'hD7);
        add_byte(MK_FILL);
        add_byte(MK_SOI);
        add_byte(MK_FILL);
        add_byte(MK_EOI);
        push_sof(MK_SOF0, 16'd17, 8'd8, 16'hFFFF, 16'hFFFF);
        push_plain(8'hC4, 16'd1);
        push_plain(8'hDB, 16'd0);
        push_plain(8'hC1, 16'd2);
        push_plain(8'hFE, 16'h0102);
        push_sof(MK_SOF2, 16'd5, 8'hFF, 16'h0000, 16'h0001);
        add_byte(MK_FILL);
        add_byte(MK_EOI);
        send_file();
        // JPEG ending inside a second frame header.
        add_byte(MK_FILL);
        add_byte(MK_SOI);
        push_sof(MK_SOF2, 16'd11, 8'h0C, 16'h0100, 16'h0200);
        push_sof(MK_SOF0, 16'd8, 8'h08, 16'h0300, 16'h0400);
        trim_file(file_bytes.size() - 3);
        send_file();

        // Hold off until every directed header has been reported.
        drain();

        // Random files over three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct <= 65;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_idle_pct <= 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                make_random_file();
                sent += file_bytes.size();
                send_file();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
